FILE: src/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies.
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef logic [31:0] word_type;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LengthAt = 6'd56;

   localparam logic [1:0] SelData = 2'd0;
   localparam logic [1:0] SelPad  = 2'd1;
   localparam logic [1:0] SelZero = 2'd2;
   localparam logic [1:0] SelLen  = 2'd3;

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_LEN   = 7'b0000100,
      ST_LOAD  = 7'b0001000,
      ST_ROUND = 7'b0010000,
      ST_ADD   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic       wr_byte;
      logic [5:0] wr_addr;
      logic [1:0] wr_sel;
      logic       add_len;
      logic       load;
      logic       round;
      logic       add_hash;
      logic       restart;
   } cmd_type;

   function automatic word_type ror(input word_type v, input int n);
      ror = (v >> n) | (v << (32 - n));
   endfunction

endpackage

FILE: src/sha_datapath.sv
// SHA-256 datapath: block buffer, message schedule window, working and hash registers.
// Depends on sha_pkg.
module sha_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sha_pkg::cmd_type    cmd,
   input  logic [7:0]          wr_data,
   input  logic [5:0]          round_idx,
   input  logic [2:0]          out_idx,
   output logic [31:0]         hash_out
);

   logic [7:0] mem_ff [64];
   logic [63:0] bits_ff, bits_in;
   sha_pkg::word_type w_ff [16];
   sha_pkg::word_type h_ff [8];
   sha_pkg::word_type v_ff [8];
   logic [7:0] wbyte;
   logic [3:0] ldword;
   logic [1:0] ldbyte;
   sha_pkg::word_type s0, s1, wnew, t1, t2, e_, a_;

   always_comb begin
      unique case (cmd.wr_sel)
         sha_pkg::SelData: wbyte = wr_data;
         sha_pkg::SelPad:  wbyte = sha_pkg::PadByte;
         sha_pkg::SelZero: wbyte = 8'h00;
         sha_pkg::SelLen:  wbyte = bits_ff[{~cmd.wr_addr[2:0], 3'd7} -: 8];
      endcase
   end

   assign ldword = round_idx[5:2];
   assign ldbyte = round_idx[1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_byte) begin
         mem_ff[cmd.wr_addr] <= wbyte;
      end
   end

   always_comb begin
      bits_in = bits_ff;
      if (cmd.restart) begin
         bits_in = '0;
      end else if (cmd.add_len) begin
         bits_in = bits_ff + 64'd8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

   always_comb begin
      s0 = sha_pkg::ror(w_ff[1], 7) ^ sha_pkg::ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = sha_pkg::ror(w_ff[14], 17) ^ sha_pkg::ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (sha_pkg::ror(v_ff[4], 6) ^ sha_pkg::ror(v_ff[4], 11)
           ^ sha_pkg::ror(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + sha_pkg::RoundK[round_idx] + w_ff[0];
      t2 = (sha_pkg::ror(v_ff[0], 2) ^ sha_pkg::ror(v_ff[0], 13) ^ sha_pkg::ror(v_ff[0], 22))
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      e_ = v_ff[3] + t1;
      a_ = t1 + t2;
   end

   // Load shifts one byte a cycle into the window; rounds shift one word.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (ldbyte == 2'd0) begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         end
         w_ff[15] <= {w_ff[15][23:0], mem_ff[{ldword, ldbyte}]};
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= wnew;
         v_ff[0] <= a_;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= e_;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
      if (cmd.load && round_idx == 6'd0) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::InitHash[i];
      end else if (cmd.add_hash) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   assign hash_out = h_ff[out_idx];

endmodule

FILE: src/sha_controller.sv
// SHA-256 sequencer: byte intake, padding, block load, rounds and digest output.
// Depends on sha_pkg.
module sha_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sha_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sha_pkg::cmd_type   cmd,
   output logic [7:0]         wr_data,
   output logic [5:0]         round_idx,
   output logic [2:0]         out_idx
);

   sha_pkg::state_type state_ff, state_in;
   logic [5:0] fill_ff, fill_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [2:0] oidx_ff, oidx_in;
   logic fin_ff, fin_in;
   logic two_ff, two_in;
   logic pad_ff, pad_in;
   logic acc;

   assign acc = req_valid && req_ready;
   assign req_ready = (state_ff == sha_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == sha_pkg::ST_OUT);
   assign wr_data = req_data.data_byte;
   assign round_idx = cnt_ff;
   assign out_idx = oidx_ff;

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      oidx_in = oidx_ff;
      fin_in = fin_ff;
      two_in = two_ff;
      pad_in = pad_ff;
      cmd = '0;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (acc) begin
               if (req_data.byte_valid) begin
                  cmd.wr_byte = 1'b1;
                  cmd.wr_addr = fill_ff;
                  cmd.add_len = 1'b1;
                  fill_in = fill_ff + 6'd1;
               end
               fin_in = req_data.last_byte;
               if (req_data.byte_valid && fill_ff == 6'd63) begin
                  state_in = sha_pkg::ST_LOAD;
                  cnt_in = '0;
               end else if (req_data.last_byte) begin
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_PAD: begin
            cmd.wr_byte = 1'b1;
            cmd.wr_addr = fill_ff;
            cmd.wr_sel = sha_pkg::SelPad;
            two_in = (fill_ff >= sha_pkg::LengthAt);
            pad_in = 1'b1;
            fill_in = fill_ff + 6'd1;
            state_in = sha_pkg::ST_LEN;
            if (fill_ff == 6'd63) begin
               state_in = sha_pkg::ST_LOAD;
               cnt_in = '0;
            end
         end
         sha_pkg::ST_LEN: begin
            cmd.wr_byte = 1'b1;
            cmd.wr_addr = fill_ff;
            cmd.wr_sel = (fill_ff >= sha_pkg::LengthAt && !two_ff) ?
                         sha_pkg::SelLen : sha_pkg::SelZero;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               state_in = sha_pkg::ST_LOAD;
               cnt_in = '0;
            end
         end
         sha_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = sha_pkg::ST_ROUND;
         end
         sha_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = sha_pkg::ST_ADD;
         end
         sha_pkg::ST_ADD: begin
            cmd.add_hash = 1'b1;
            oidx_in = '0;
            if (!fin_ff) begin
               state_in = sha_pkg::ST_IDLE;
            end else if (!pad_ff) begin
               state_in = sha_pkg::ST_PAD;
            end else if (two_ff) begin
               two_in = 1'b0;
               state_in = sha_pkg::ST_LEN;
            end else begin
               state_in = sha_pkg::ST_OUT;
            end
         end
         sha_pkg::ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  cmd.restart = 1'b1;
                  fin_in = 1'b0;
                  pad_in = 1'b0;
                  fill_in = '0;
                  state_in = sha_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         fill_ff <= '0;
         cnt_ff <= '0;
         oidx_ff <= '0;
         fin_ff <= 1'b0;
         two_ff <= 1'b0;
         pad_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
         oidx_ff <= oidx_in;
         fin_ff <= fin_in;
         two_ff <= two_in;
         pad_ff <= pad_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_out_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fin_ff) else $error("digest without message end");
   a_round_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(cmd.round) |-> $past(state_ff == sha_pkg::ST_LOAD))
      else $error("rounds began without load");

endmodule

FILE: src/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: joins the controller and the datapath.
// Depends on sha_pkg, sha_controller and sha_datapath.
//
// Usage: the request channel takes one byte per request (data_byte, byte_valid,
// last_byte). A request with last_byte high ends the message; a request with
// byte_valid low and last_byte high ends it without adding a byte.
// Each request that completes a 64-byte block holds off the next request while the
// schedule is loaded one byte at a time, 64 rounds run on one round unit and the
// result is added into the hash. Other bytes are taken without a hold-off.
// Finishing adds one padding write per remaining byte of each padded block and
// one or two further compressions.
// The response channel then presents eight digest words, index 0 first, with
// last_word on index 7; a stalled receiver holds the current word, and no
// request is taken until all eight are delivered. The next message then starts
// from the initial hash. Synchronous reset restores the initial hash and clears
// the fill and bit counts; the block buffer is not cleared.
module sha256_stream_hasher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sha_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sha_pkg::rsp_type  rsp_data
);

   sha_pkg::cmd_type cmd;
   logic [7:0] wr_data;
   logic [5:0] round_idx;
   logic [2:0] out_idx;
   logic [31:0] hash_out;

   sha_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .wr_data(wr_data), .round_idx(round_idx), .out_idx(out_idx)
   );

   sha_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .wr_data(wr_data),
      .round_idx(round_idx), .out_idx(out_idx), .hash_out(hash_out)
   );

   assign rsp_data.digest_word = hash_out;
   assign rsp_data.word_index = out_idx;
   assign rsp_data.last_word = (out_idx == 3'd7);

endmodule
